### design/tcw_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the text console writer.
// Used by every design module and by the checker; depends on nothing.
package tcw_pkg;

	// Screen geometry.
	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = COLUMNS * ROWS;

	localparam int ADDR_W = $clog2(CELLS);
	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ROW_W  = $clog2(ROWS);

	// Field widths fixed by the stream format.
	localparam int CHAR_W    = 8;
	localparam int ATTR_W    = 8;
	localparam int IN_COL_W  = 7;
	localparam int IN_ROW_W  = 5;
	localparam int POS_W     = 11;
	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 32;
	localparam int S_PAD_W   = S_TDATA_W - CHAR_W - IN_COL_W - IN_ROW_W;
	localparam int M_PAD_W   = M_TDATA_W - POS_W - CHAR_W - ATTR_W;

	// Character and attribute constants.
	localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
	localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
	localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h07;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [ATTR_W+CHAR_W-1:0] cell_t;

	// Operation codes carried in the input tuser.
	typedef enum logic [1:0] {
		OP_PUT   = 2'd0,
		OP_SET   = 2'd1,
		OP_CLEAR = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	// Write request to the screen memory.
	typedef struct packed {
		logic  en;
		addr_t addr;
		cell_t data;
	} mem_wr_t;

	// Finished result handed from the sequencer to the output stage.
	typedef struct packed {
		logic [POS_W-1:0]  pos;
		logic [CHAR_W-1:0] cell_char;
		logic [ATTR_W-1:0] cell_attr;
		logic              scrolled;
	} res_t;

endpackage

### design/tcw_screen_mem.sv
`timescale 1ns / 1ps
// Screen cell store: one write port and one read port with registered read data.
// Depends on tcw_pkg for the geometry and cell types.
module tcw_screen_mem (
	input  logic             clk,
	input  tcw_pkg::mem_wr_t wr,
	input  tcw_pkg::addr_t   rd_addr,
	output tcw_pkg::cell_t   rd_data
);
	import tcw_pkg::*;

	cell_t mem [CELLS];
	cell_t rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// Read port with registered read data.
	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

### design/tcw_seq.sv
`timescale 1ns / 1ps
// Sequencer of the text console: cursor, per-op control and the sweeps for
// init, clear and scroll over the screen memory. Depends on tcw_pkg.
module tcw_seq (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   in_op,
	input  logic [tcw_pkg::CHAR_W-1:0]   in_char,
	input  logic [tcw_pkg::IN_COL_W-1:0] in_col,
	input  logic [tcw_pkg::IN_ROW_W-1:0] in_row,
	input  logic [tcw_pkg::ATTR_W-1:0]   color,
	output tcw_pkg::mem_wr_t             mem_wr,
	output tcw_pkg::addr_t               rd_addr,
	input  tcw_pkg::cell_t               rd_data,
	output tcw_pkg::res_t                res,
	output logic                         res_valid,
	input  logic                         res_take
);
	import tcw_pkg::*;

	localparam addr_t LAST_ADDR  = ADDR_W'(CELLS - 1);
	localparam addr_t COPY_FIRST = ADDR_W'(COLUMNS);
	localparam addr_t BLANK_BASE = ADDR_W'((ROWS - 1) * COLUMNS);

	typedef enum logic [5:0] {
		ST_INIT  = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_READ  = 6'b000100,
		ST_COPY  = 6'b001000,
		ST_BLANK = 6'b010000,
		ST_FILL  = 6'b100000
	} state_t;

	state_t             state_q;
	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;
	addr_t              ptr_q;
	logic               cp_vld_s1;
	addr_t              cp_addr_s1;
	logic               res_valid_q;
	logic [CHAR_W-1:0]  res_char_q;
	logic [ATTR_W-1:0]  res_attr_q;
	logic               res_scr_q;

	logic               accept;
	op_t                op;
	logic [COL_W-1:0]   in_col_c;
	logic [ROW_W-1:0]   in_row_c;
	addr_t              cur_addr;
	addr_t              in_addr;
	logic               col_last;
	logic               row_last;
	logic               is_newline;

	assign in_ready = (state_q == ST_IDLE) && !res_valid_q;
	assign accept   = in_valid && in_ready;
	assign op       = op_t'(in_op);

	// Saturate the requested column and row to the screen.
	assign in_col_c = (32'(in_col) >= COLUMNS) ? COL_W'(COLUMNS - 1) : COL_W'(in_col);
	assign in_row_c = (32'(in_row) >= ROWS) ? ROW_W'(ROWS - 1) : ROW_W'(in_row);

	// Linear addresses of the cursor and of the requested cell.
	assign cur_addr = ADDR_W'(32'(row_q) * COLUMNS) + ADDR_W'(col_q);
	assign in_addr  = ADDR_W'(32'(in_row_c) * COLUMNS) + ADDR_W'(in_col_c);

	assign col_last   = (32'(col_q) + 1) >= COLUMNS;
	assign row_last   = (32'(row_q) + 1) >= ROWS;
	assign is_newline = (in_char == NEWLINE_CHAR);

	// Read address: the sweep pointer during the copy phase of a scroll, else the requested cell.
	// The copy reads one row ahead of where it writes, so no forwarding is needed.
	assign rd_addr = (state_q == ST_COPY) ? ptr_q : in_addr;

	// Write port arbitration: the copy pipeline first, then sweeps, then puts.
	always_comb begin
		mem_wr = '0;
		if (cp_vld_s1) begin
			mem_wr.en   = 1'b1;
			mem_wr.addr = cp_addr_s1;
			mem_wr.data = rd_data;
		end else if (state_q == ST_INIT) begin
			mem_wr.en   = 1'b1;
			mem_wr.addr = ptr_q;
			mem_wr.data = {RESET_ATTR, BLANK_CHAR};
		end else if ((state_q == ST_FILL) || (state_q == ST_BLANK)) begin
			mem_wr.en   = 1'b1;
			mem_wr.addr = ptr_q;
			mem_wr.data = {color, BLANK_CHAR};
		end else if (accept && (op == OP_PUT) && !is_newline) begin
			mem_wr.en   = 1'b1;
			mem_wr.addr = cur_addr;
			mem_wr.data = {color, in_char};
		end
	end

	// Control, cursor and result holding register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			col_q       <= '0;
			row_q       <= '0;
			ptr_q       <= '0;
			cp_vld_s1   <= 1'b0;
			cp_addr_s1  <= '0;
			res_valid_q <= 1'b0;
			res_char_q  <= '0;
			res_attr_q  <= '0;
			res_scr_q   <= 1'b0;
		end else begin
			cp_vld_s1 <= 1'b0;
			if (res_take) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_INIT: begin
					if (ptr_q == LAST_ADDR) begin
						ptr_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						res_char_q <= '0;
						res_attr_q <= '0;
						res_scr_q  <= 1'b0;
						case (op)
							OP_PUT: begin
								if (is_newline || col_last) begin
									col_q <= '0;
									if (row_last) begin
										ptr_q   <= COPY_FIRST;
										state_q <= ST_COPY;
									end else begin
										row_q       <= row_q + 1'b1;
										res_valid_q <= 1'b1;
									end
								end else begin
									col_q       <= col_q + 1'b1;
									res_valid_q <= 1'b1;
								end
							end
							OP_SET: begin
								col_q       <= in_col_c;
								row_q       <= in_row_c;
								res_valid_q <= 1'b1;
							end
							OP_CLEAR: begin
								ptr_q   <= '0;
								state_q <= ST_FILL;
							end
							OP_READ: begin
								state_q <= ST_READ;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_READ: begin
					res_char_q  <= rd_data[CHAR_W-1:0];
					res_attr_q  <= rd_data[ATTR_W+CHAR_W-1:CHAR_W];
					res_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				ST_COPY: begin
					// Read one row down now, write it one row up next cycle.
					cp_vld_s1  <= 1'b1;
					cp_addr_s1 <= ptr_q - COPY_FIRST;
					if (ptr_q == LAST_ADDR) begin
						ptr_q   <= BLANK_BASE;
						state_q <= ST_BLANK;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				ST_BLANK: begin
					// The last copy write owns the port on the first cycle here.
					if (!cp_vld_s1) begin
						if (ptr_q == LAST_ADDR) begin
							res_scr_q   <= 1'b1;
							res_valid_q <= 1'b1;
							state_q     <= ST_IDLE;
						end else begin
							ptr_q <= ptr_q + 1'b1;
						end
					end
				end
				ST_FILL: begin
					if (ptr_q == LAST_ADDR) begin
						col_q       <= '0;
						row_q       <= '0;
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res_valid     = res_valid_q;
	assign res.pos       = POS_W'(cur_addr);
	assign res.cell_char = res_char_q;
	assign res.cell_attr = res_attr_q;
	assign res.scrolled  = res_scr_q;

endmodule

### design/text_console_writer_core.sv
`timescale 1ns / 1ps
// Text console writer: a character-cell screen of COLUMNS x ROWS cells kept in one
// synchronous memory, fed by a command stream and answering one beat per command.
// After reset the block runs a clearing pass that fills the screen with spaces in
// attribute 0x07; s_tready stays low meanwhile. After a put, a newline without
// scroll or a set cursor, no new command is taken until its result has left the
// holding register for the output register; a cell read also first waits for the
// registered memory read data. A scroll copies (ROWS-1)*COLUMNS cells through the
// single memory read port at one cell a cycle and then blanks the bottom row; a
// clear writes every cell. One finished result can wait in a holding register while
// the output beat is still stalled. Depends on tcw_pkg, tcw_screen_mem and tcw_seq.
module text_console_writer_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// char_code [7:0], col [14:8], row [19:15], zero [23:20]
	input  logic [tcw_pkg::S_TDATA_W-1:0] s_tdata,
	// op [1:0]
	input  logic [1:0]                    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// cursor_pos [10:0], cell_char [18:11], cell_attr [26:19], zero [31:27]
	output logic [tcw_pkg::M_TDATA_W-1:0] m_tdata,
	// scrolled [0]
	output logic [0:0]                    m_tuser,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tcw_pkg::ATTR_W-1:0]    cfg_data
);
	import tcw_pkg::*;

	logic [ATTR_W-1:0] color_q;
	logic              m_valid_q;
	res_t              m_res_q;
	res_t              res;
	logic              res_valid;
	logic              res_take;
	mem_wr_t           mem_wr;
	addr_t             rd_addr;
	cell_t             rd_data;

	// Text color register.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= RESET_ATTR;
		end else if (cfg_valid && cfg_ready) begin
			color_q <= cfg_data;
		end
	end

	tcw_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_op     (s_tuser),
		.in_char   (s_tdata[CHAR_W-1:0]),
		.in_col    (s_tdata[CHAR_W+IN_COL_W-1:CHAR_W]),
		.in_row    (s_tdata[CHAR_W+IN_COL_W+IN_ROW_W-1:CHAR_W+IN_COL_W]),
		.color     (color_q),
		.mem_wr    (mem_wr),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.res       (res),
		.res_valid (res_valid),
		.res_take  (res_take)
	);

	tcw_screen_mem u_mem (
		.clk     (clk),
		.wr      (mem_wr),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Output register: loads the held result whenever it is empty or being taken.
	assign res_take = res_valid && (!m_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			m_res_q   <= '0;
		end else if (res_take) begin
			m_valid_q <= 1'b1;
			m_res_q   <= res;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {M_PAD_W'(0), m_res_q.cell_attr, m_res_q.cell_char, m_res_q.pos};
	assign m_tuser  = m_res_q.scrolled;

endmodule

### design/tcw_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the text console writer, bound to the top level.
// Depends on tcw_pkg and text_console_writer_core.
module tcw_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [tcw_pkg::S_TDATA_W-1:0] s_tdata,
	input logic [1:0]                    s_tuser,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [tcw_pkg::M_TDATA_W-1:0] m_tdata,
	input logic [0:0]                    m_tuser,
	input logic                          cfg_valid,
	input logic                          cfg_ready,
	input logic [tcw_pkg::ATTR_W-1:0]    cfg_data
);
	import tcw_pkg::*;

	localparam logic [POS_W-1:0] SCROLL_POS = POS_W'((ROWS - 1) * COLUMNS);

	// A stalled result beat holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// The reported cursor always lies on the screen.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (32'(m_tdata[POS_W-1:0]) < CELLS))
		else $error("cursor position off screen");

	// A scroll leaves the cursor at the start of the bottom row.
	a_scroll_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> (m_tdata[POS_W-1:0] == SCROLL_POS))
		else $error("scroll left cursor away from bottom row start");

	// A scroll never carries cell read data.
	a_scroll_no_cell: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> (m_tdata[M_TDATA_W-1:POS_W] == '0))
		else $error("scroll beat carries cell data");

endmodule

bind text_console_writer_core tcw_checker u_tcw_checker (.*);
